[rtl/core/per_source_leaky_bucket_limiter_defines.svh]
// -----------------------------------------------------------------------------
// Per-source leaky bucket limiter: assertion macros
// Shared concurrent assertion forms, clocked on clk with arst_n as disable.
// -----------------------------------------------------------------------------
`ifndef PER_SOURCE_LEAKY_BUCKET_LIMITER_DEFINES_SVH
`define PER_SOURCE_LEAKY_BUCKET_LIMITER_DEFINES_SVH

// same-cycle implication
`define PLBL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plbl assertion failed");

// next-cycle implication
`define PLBL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plbl assertion failed");

`endif

[rtl/core/plbl_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Per-source leaky bucket limiter package
// Sizes, verdict codes, register indexes and the bucket entry layout.
// -----------------------------------------------------------------------------
package plbl_pkg;

	localparam int BUCKETS   = 1024;
	localparam int IDX_W     = $clog2(BUCKETS);
	localparam int TIME_BITS = 48;
	localparam int BURST_W   = 16;
	localparam int PERIOD_W  = 32;
	localparam int LIMIT_W   = BURST_W + PERIOD_W;
	localparam int CNT_W     = $clog2(TIME_BITS);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BURST  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'd1;

	localparam logic [1:0] VERDICT_PASS     = 2'd0;
	localparam logic [1:0] VERDICT_OVER     = 2'd1;
	localparam logic [1:0] VERDICT_FULL     = 2'd2;
	localparam logic [1:0] VERDICT_DISABLED = 2'd3;

	typedef struct packed {
		logic                 valid;
		logic [1:0]           kind;
		logic [63:0]          addr_high;
		logic [63:0]          addr_low;
		logic [TIME_BITS-1:0] last_time;
		logic [BURST_W-1:0]   fill;
	} entry_t;

endpackage

[rtl/core/plbl_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Per-source leaky bucket limiter channels
// Request channel (source address and time) and response channel (verdict).
// -----------------------------------------------------------------------------
interface plbl_req_if import plbl_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [1:0]           address_kind;
	logic [63:0]          address_high;
	logic [63:0]          address_low;
	logic [TIME_BITS-1:0] now_ticks;

	modport source (output valid, address_kind, address_high, address_low, now_ticks,
		input ready);
	modport sink (input valid, address_kind, address_high, address_low, now_ticks,
		output ready);
endinterface

interface plbl_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;
	logic       drop;

	modport source (output valid, verdict, drop, input ready);
	modport sink (input valid, verdict, drop, output ready);
endinterface

[rtl/core/per_source_leaky_bucket_limiter.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Per-source leaky bucket limiter
// Bucket table in one memory, scanned by a sequencer, with a serial divider.
// -----------------------------------------------------------------------------
// Usage:
//   req carries one packet beat: address kind, 128 address bits, tick time.
//   rsp returns one beat per packet: verdict and drop flag.
//   wr_en/wr_idx/wr_data write burst_limit (0) and leak_period (1).
// Timing:
//   After reset the table is cleared, one entry a cycle, with req.ready low.
//   A packet with limiting disabled skips the scan and the divider.
//   Otherwise the match scan reads one entry a cycle from the table memory
//   (ending early on a hit), and a hit then runs a restoring divider.
//   req.ready is high only while the sequencer is idle.
// Stall:
//   The result sits in an output register; the next packet is taken while
//   it waits, and its own result waits in the sequencer until rsp is free.
// -----------------------------------------------------------------------------
`include "per_source_leaky_bucket_limiter_defines.svh"

module per_source_leaky_bucket_limiter import plbl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_idx,
	input  logic [CFG_W-1:0]     wr_data,
	plbl_req_if.sink             req,
	plbl_rsp_if.source           rsp
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_UPD  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;

	localparam logic [IDX_W:0] IDX_END = (IDX_W+1)'(BUCKETS);

	logic [2:0]           state_q;
	logic [BURST_W-1:0]   burst_q;
	logic [PERIOD_W-1:0]  period_q;
	logic [LIMIT_W-1:0]   limit_q;

	logic [1:0]           kind_q;
	logic [63:0]          hi_q;
	logic [63:0]          lo_q;
	logic [TIME_BITS-1:0] now_q;

	logic [IDX_W:0]       idx_q;
	logic                 rdv_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 claim_found_q;
	logic [IDX_W-1:0]     claim_idx_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic [TIME_BITS-1:0] last_q;
	logic [BURST_W-1:0]   fill_q;

	logic [TIME_BITS-1:0] quo_q;
	logic [PERIOD_W-1:0]  rem_q;
	logic [CNT_W-1:0]     cnt_q;

	logic [1:0]           res_q;
	logic                 rsp_vld_q;
	logic [1:0]           rsp_verdict_q;
	logic                 rsp_drop_q;

	entry_t               mem [BUCKETS];
	entry_t               rd_q;
	logic                 we;
	logic [IDX_W-1:0]     waddr;
	entry_t               wdata;

	logic                 match;
	logic                 claimable;
	logic                 scan_end;
	logic [PERIOD_W:0]    trial;
	logic                 ge;
	logic                 back;
	logic [BURST_W-1:0]   fill_lk;
	logic [TIME_BITS-1:0] last_lk;
	logic                 pass;

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = rsp_vld_q;
	assign rsp.verdict = rsp_verdict_q;
	assign rsp.drop    = rsp_drop_q;

	assign match = rd_q.valid && rd_q.kind == kind_q && rd_q.addr_high == hi_q &&
		rd_q.addr_low == lo_q;
	assign claimable = !rd_q.valid || now_q < rd_q.last_time ||
		64'(now_q - rd_q.last_time) > 64'(limit_q);
	assign scan_end = (idx_q == IDX_END) && !rdv_s1;

	assign trial = {rem_q, quo_q[TIME_BITS-1]};
	assign ge    = trial >= {1'b0, period_q};

	always_comb begin
		back    = now_q < last_q;
		fill_lk = fill_q;
		last_lk = last_q;
		if (quo_q > TIME_BITS'(fill_q)) begin
			fill_lk = '0;
			last_lk = now_q;
		end else begin
			fill_lk = fill_q - quo_q[BURST_W-1:0];
			last_lk = back ? last_q : now_q - TIME_BITS'(rem_q);
		end
		pass = fill_lk < burst_q;
	end

	always_comb begin
		we              = 1'b0;
		waddr           = idx_q[IDX_W-1:0];
		wdata.valid     = 1'b1;
		wdata.kind      = kind_q;
		wdata.addr_high = hi_q;
		wdata.addr_low  = lo_q;
		wdata.last_time = now_q;
		wdata.fill      = BURST_W'(1);
		case (state_q)
			ST_CLR: begin
				we          = 1'b1;
				wdata.valid = 1'b0;
			end
			ST_SCAN: begin
				we    = scan_end && claim_found_q;
				waddr = claim_idx_q;
			end
			ST_UPD: begin
				we              = 1'b1;
				waddr           = hit_idx_q;
				wdata.last_time = last_lk;
				wdata.fill      = pass ? fill_lk + BURST_W'(1) : fill_lk;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q  <= '0;
			period_q <= '0;
			limit_q  <= '0;
		end else begin
			limit_q <= LIMIT_W'(burst_q) * LIMIT_W'(period_q);
			if (wr_en) begin
				case (wr_idx)
					REG_BURST:  burst_q  <= wr_data[BURST_W-1:0];
					REG_PERIOD: period_q <= wr_data[PERIOD_W-1:0];
					default:    burst_q  <= burst_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req.valid) begin
			kind_q <= req.address_kind;
			hi_q   <= req.address_high;
			lo_q   <= req.address_low;
			now_q  <= req.now_ticks;
		end
		if (state_q == ST_SCAN && rdv_s1) begin
			if (match) begin
				hit_idx_q <= idx_s1;
				last_q    <= rd_q.last_time;
				fill_q    <= rd_q.fill;
			end else if (claimable && !claim_found_q) begin
				claim_idx_q <= idx_s1;
			end
		end
		if (state_q == ST_SCAN && rdv_s1 && match) begin
			quo_q <= (now_q < rd_q.last_time) ? '0 : now_q - rd_q.last_time;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? PERIOD_W'(trial - {1'b0, period_q}) : trial[PERIOD_W-1:0];
			quo_q <= {quo_q[TIME_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			idx_q         <= '0;
			rdv_s1        <= 1'b0;
			idx_s1        <= '0;
			claim_found_q <= 1'b0;
			cnt_q         <= '0;
			res_q         <= VERDICT_PASS;
			rsp_vld_q     <= 1'b0;
			rsp_verdict_q <= VERDICT_PASS;
			rsp_drop_q    <= 1'b0;
		end else begin
			if (rsp_vld_q && rsp.ready && state_q != ST_FIN) begin
				rsp_vld_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IDX_END - 1'b1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					idx_q         <= '0;
					rdv_s1        <= 1'b0;
					claim_found_q <= 1'b0;
					if (req.valid) begin
						if (burst_q == '0 || period_q == '0) begin
							res_q   <= VERDICT_DISABLED;
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rdv_s1 && match) begin
						rdv_s1  <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						if (rdv_s1 && claimable) begin
							claim_found_q <= 1'b1;
						end
						if (idx_q != IDX_END) begin
							idx_q  <= idx_q + 1'b1;
							idx_s1 <= idx_q[IDX_W-1:0];
							rdv_s1 <= 1'b1;
						end else begin
							rdv_s1 <= 1'b0;
						end
						if (scan_end) begin
							res_q   <= claim_found_q ? VERDICT_PASS : VERDICT_FULL;
							state_q <= ST_FIN;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(TIME_BITS - 1)) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					res_q   <= pass ? VERDICT_PASS : VERDICT_OVER;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q     <= 1'b1;
						rsp_verdict_q <= res_q;
						rsp_drop_q    <= (res_q == VERDICT_OVER) || (res_q == VERDICT_FULL);
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`PLBL_ASSERT_NOW(a_drop_code, rsp_vld_q, rsp_drop_q == ((rsp_verdict_q == VERDICT_OVER) || (rsp_verdict_q == VERDICT_FULL)))
	`PLBL_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready)
	`PLBL_ASSERT_NOW(a_no_take_in_clear, state_q == ST_CLR, !req.ready && !rsp_vld_q)
	`PLBL_ASSERT_NOW(a_div_count, state_q == ST_DIV, cnt_q < CNT_W'(TIME_BITS))

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Per-source leaky bucket limiter testbench
// Drives packet beats under several burst/period settings, predicts each
// verdict with a bucket table of its own and checks every response beat in
// order. Covers disabled limiting, leaking, over-limit, time going backwards,
// reclaiming of drained buckets and a fill left above a lowered limit.
// -----------------------------------------------------------------------------
module tb;
	import plbl_pkg::*;

	class verdict_scoreboard;
		bit [BURST_W-1:0]   burst;
		bit [PERIOD_W-1:0]  period;
		bit                 vld [BUCKETS];
		bit [1:0]           kd [BUCKETS];
		bit [63:0]          ah [BUCKETS];
		bit [63:0]          al [BUCKETS];
		bit [TIME_BITS-1:0] last [BUCKETS];
		bit [BURST_W-1:0]   fill [BUCKETS];
		bit [2:0]           verdict_q[$];
		int                 errors;
		int                 seen [4];

		function new();
			foreach (vld[i]) vld[i] = 0;
			burst = 0;
			period = 0;
			errors = 0;
			foreach (seen[i]) seen[i] = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, bit [CFG_W-1:0] data);
			if (idx == REG_BURST)
				burst = data[BURST_W-1:0];
			else
				period = data[PERIOD_W-1:0];
		endfunction

		function void note_packet(bit [1:0] kind, bit [63:0] hi, bit [63:0] lo,
				bit [TIME_BITS-1:0] now_t);
			int b;
			bit [63:0] now, limit, interval, expired;
			bit [1:0] v;
			now = 64'(now_t);
			b = -1;
			if (burst == 0 || period == 0) begin
				v = VERDICT_DISABLED;
			end else begin
				for (int i = 0; i < BUCKETS; i++) begin
					if (vld[i] && kd[i] == kind && ah[i] == hi && al[i] == lo) begin
						b = i;
						break;
					end
				end
				if (b < 0) begin
					limit = 64'(burst) * 64'(period);
					for (int i = 0; i < BUCKETS; i++) begin
						if (!vld[i] || now < 64'(last[i]) || now - 64'(last[i]) > limit) begin
							vld[i] = 1;
							kd[i] = kind;
							ah[i] = hi;
							al[i] = lo;
							last[i] = now_t;
							fill[i] = 0;
							b = i;
							break;
						end
					end
				end
				if (b < 0) begin
					v = VERDICT_FULL;
				end else begin
					interval = (now < 64'(last[b])) ? 64'd0 : now - 64'(last[b]);
					expired = interval / 64'(period);
					if (expired > 64'(fill[b])) begin
						fill[b] = 0;
						last[b] = now_t;
					end else begin
						fill[b] = fill[b] - expired[BURST_W-1:0];
						last[b] = last[b] + TIME_BITS'(expired * 64'(period));
					end
					if (fill[b] < burst) begin
						fill[b] = fill[b] + 1'b1;
						v = VERDICT_PASS;
					end else begin
						v = VERDICT_OVER;
					end
				end
			end
			verdict_q.push_back({v, (v == VERDICT_OVER || v == VERDICT_FULL)});
		endfunction

		function void check_result(logic [1:0] verdict, logic drop);
			bit [2:0] exp_r;
			if (verdict_q.size() == 0) begin
				$error("response beat with nothing pending: verdict %0d drop %0d",
					verdict, drop);
				errors++;
				return;
			end
			exp_r = verdict_q.pop_front();
			seen[exp_r[2:1]]++;
			if (verdict !== exp_r[2:1]) begin
				$error("verdict: expected %0d, got %0d", exp_r[2:1], verdict);
				errors++;
			end
			if (drop !== exp_r[0]) begin
				$error("drop: expected %0d, got %0d", exp_r[0], drop);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_idx;
	logic [CFG_W-1:0]     wr_data;
	bit                   idle_on;
	int                   sent;

	plbl_req_if req ();
	plbl_rsp_if rsp ();

	verdict_scoreboard sb = new();

	per_source_leaky_bucket_limiter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_idx  (wr_idx),
		.wr_data (wr_data),
		.req     (req),
		.rsp     (rsp)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	initial begin
		#40ms;
		$display("FAIL per_source_leaky_bucket_limiter");
		$finish;
	end

	// response side: check beats, stall in random bursts
	initial begin
		int stall;
		stall = 0;
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				sb.check_result(rsp.verdict, rsp.drop);
			if (stall > 0) begin
				stall--;
				rsp.ready <= (stall == 0);
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 6);
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= arst_n;
			end
		end
	end

	task automatic send_packet(bit [1:0] kind, bit [63:0] hi, bit [63:0] lo,
			bit [TIME_BITS-1:0] now_t);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req.valid        <= 1'b1;
		req.address_kind <= kind;
		req.address_high <= hi;
		req.address_low  <= lo;
		req.now_ticks    <= now_t;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);
		sb.note_packet(kind, hi, lo, now_t);
		sent++;
	endtask

	// hold off until every response is back and the sequencer has settled
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		wr_en   <= 1'b1;
		wr_idx  <= idx;
		wr_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_limits(bit [BURST_W-1:0] burst, bit [PERIOD_W-1:0] period);
		drain();
		write_reg(REG_BURST, {16'($urandom_range(0, 65535)), burst});
		write_reg(REG_PERIOD, period);
	endtask

	task automatic random_phase(int count, bit [PERIOD_W-1:0] period);
		bit [1:0]           pk [8];
		bit [63:0]          ph [8];
		bit [63:0]          pl [8];
		bit [TIME_BITS-1:0] cur;
		bit [63:0]          step_max;
		int                 k;
		for (int i = 0; i < 8; i++) begin
			pk[i] = $urandom_range(0, 3);
			ph[i] = (pk[i] == 1) ? 64'd0 : {$urandom, $urandom};
			pl[i] = {$urandom, $urandom};
		end
		cur = {$urandom, $urandom};
		step_max = (period > 1000) ? 64'(period) * 3 : 64'(period) * 4 + 2;
		for (int n = 0; n < count; n++) begin
			k = $urandom_range(0, 15);
			if (k == 0)
				cur = {$urandom, $urandom};
			else if (k == 1)
				cur = cur - TIME_BITS'($urandom_range(1, 64));
			else
				cur = cur + TIME_BITS'({$urandom, $urandom} % step_max);
			if ($urandom_range(0, 9) == 0) begin
				send_packet($urandom_range(0, 3), {$urandom, $urandom},
					{$urandom, $urandom}, cur);
			end else begin
				k = $urandom_range(0, 7);
				send_packet(pk[k], ph[k], pl[k], cur);
			end
		end
	endtask

	initial begin
		bit [TIME_BITS-1:0] base;
		bit [TIME_BITS-1:0] tmax;
		bit [63:0]          ones;
		sent = 0;
		idle_on = 1'b1;
		tmax = '1;
		ones = '1;
		arst_n           = 1'b0;
		wr_en            <= 1'b0;
		wr_idx           <= REG_BURST;
		wr_data          <= '0;
		req.valid        <= 1'b0;
		req.address_kind <= '0;
		req.address_high <= '0;
		req.address_low  <= '0;
		req.now_ticks    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (req.ready !== 1'b1) @(posedge clk);

		// disabled at reset, then with only one of the two registers set
		send_packet(2'd0, 64'd0, 64'd0, '0);
		send_packet(2'd3, ones, ones, tmax);
		set_limits(16'd4, 32'd0);
		send_packet(2'd1, 64'd0, 64'h0000_0000_c0a8_0001, 48'd10);
		set_limits(16'd0, 32'd10);
		send_packet(2'd2, ones, 64'd1, 48'd20);

		// leak, over limit, backwards time, distinct kinds
		set_limits(16'd2, 32'd10);
		send_packet(2'd1, 64'd0, 64'd5, 48'd100);
		send_packet(2'd1, 64'd0, 64'd5, 48'd100);
		send_packet(2'd1, 64'd0, 64'd5, 48'd100);
		send_packet(2'd1, 64'd0, 64'd5, 48'd115);
		send_packet(2'd1, 64'd0, 64'd5, 48'd50);
		send_packet(2'd2, 64'd0, 64'd5, 48'd50);
		send_packet(2'd1, 64'd0, 64'd5, 48'd1000);
		send_packet(2'd3, ones, ones, 48'd1000);
		send_packet(2'd0, ones, ones, 48'd1001);

		// extreme limits near the top of the time range
		set_limits(16'hffff, 32'hffff_ffff);
		send_packet(2'd2, ones, 64'd0, tmax - 48'd5);
		send_packet(2'd2, ones, 64'd0, tmax);
		send_packet(2'd2, 64'd0, ones, tmax);

		// reclaim buckets whose last time lies ahead, around a high time base
		drain();
		base = 48'h10_0000_0000;
		send_packet(2'd2, 64'hfeed_0000_0000_0000, 64'd0, base);
		send_packet(2'd2, 64'hfeed_0000_0000_0000, 64'd0, base + 48'd1);
		send_packet(2'd1, 64'd0, 64'hdead_beef, base);
		send_packet(2'd3, ones, ones, base + 48'd7);
		send_packet(2'd1, 64'd0, 64'hdead_beef, base - 48'd1);
		// fill now above a lowered limit
		set_limits(16'd1, 32'd1);
		send_packet(2'd2, 64'hfeed_0000_0000_0000, 64'd0, base + 48'd1);

		// pause the sender until everything is back
		drain();

		set_limits(16'd1, 32'd1);
		random_phase(70, 32'd1);
		set_limits(16'd3, 32'd10);
		random_phase(70, 32'd10);
		set_limits(16'd0, 32'd77);
		random_phase(15, 32'd77);
		set_limits(16'd2, 32'd100);
		random_phase(70, 32'd100);
		set_limits(16'hffff, 32'hffff_ffff);
		random_phase(70, 32'hffff_ffff);
		set_limits(16'($urandom_range(1, 8)), 32'($urandom_range(1, 50)));
		random_phase(70, sb.period);
		set_limits(16'd5, 32'd7);
		random_phase(70, 32'd7);
		idle_on = 1'b0;
		set_limits(16'd4, 32'd3);
		random_phase(70, 32'd3);

		drain();
		repeat (100) @(posedge clk);
		if (sb.verdict_q.size() != 0) begin
			$error("%0d responses never arrived", sb.verdict_q.size());
			sb.errors++;
		end
		$display("Run covered %0d packet beats: %0d passed, %0d over limit,", sent,
			sb.seen[VERDICT_PASS], sb.seen[VERDICT_OVER]);
		$display("%0d table full, %0d with limiting disabled.",
			sb.seen[VERDICT_FULL], sb.seen[VERDICT_DISABLED]);
		if (sb.errors == 0)
			$display("PASS per_source_leaky_bucket_limiter");
		else
			$display("FAIL per_source_leaky_bucket_limiter");
		$finish;
	end
endmodule

[per_source_leaky_bucket_limiter.f]
+incdir+rtl/core
rtl/core/plbl_pkg.sv
rtl/core/plbl_if.sv
rtl/core/per_source_leaky_bucket_limiter.sv
tb/sv/tb.sv
